// File: hdl/lpcfsl_pkg.sv
// Package for the LPC frame stream length scanner.
// Holds the payload widths, the field kind codes, the field widths and the special energy values.
// No dependencies.
package lpcfsl_pkg;

   // Payload widths
   localparam int BYTE_BITS   = 8;
   localparam int LENGTH_BITS = 16;   // width of the internal byte counter
   localparam int OUT_BITS    = 16;   // width of the reported length

   // Field kind codes
   localparam logic [2:0] KIND_ENERGY = 3'd0;
   localparam logic [2:0] KIND_REPEAT = 3'd1;
   localparam logic [2:0] KIND_PITCH  = 3'd2;
   localparam logic [2:0] KIND_KLOW   = 3'd3;
   localparam logic [2:0] KIND_KHIGH  = 3'd4;

   // Field widths in bits
   localparam logic [4:0] ENERGY_WIDTH = 5'd4;
   localparam logic [4:0] REPEAT_WIDTH = 5'd1;
   localparam logic [4:0] PITCH_WIDTH  = 5'd6;
   localparam logic [4:0] KLOW_WIDTH   = 5'(5 + 5 + 4 + 4);
   localparam logic [4:0] KHIGH_WIDTH  = 5'(4 + 4 + 4 + 3 + 3 + 3);

   // Special energy values
   localparam logic [5:0] ENERGY_STOP   = 6'hF;
   localparam logic [5:0] ENERGY_SILENT = 6'h0;

endpackage

// File: hdl/lpcfsl_byte_if.sv
// Stream byte channel: valid/ready handshake carrying one bitstream byte.
// Depends on lpcfsl_pkg for the byte width.
interface lpcfsl_byte_if
   import lpcfsl_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

// File: hdl/lpcfsl_len_if.sv
// Stream length channel: valid/ready handshake carrying one stream length.
// Depends on lpcfsl_pkg for the length width.
interface lpcfsl_len_if
   import lpcfsl_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] stream_length;

   modport source (output valid, output stream_length, input ready);
   modport sink   (input valid, input stream_length, output ready);
endinterface

// File: hdl/lpc_frame_stream_length_scanner.sv
// LPC frame stream length scanner: walks the frames of an LPC bitstream, one
// byte per request, and reports the stream length in bytes at each stop frame.
// A request is held in the input register, its eight bits are walked, and at a stop
// frame the length is written to the result register that drives rsp_if.
// Throughput: one request per cycle; only a stalled, full result register holds.
// Reset: synchronous, active high; clears the frame walk state and the count.
module lpc_frame_stream_length_scanner
   import lpcfsl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   lpcfsl_byte_if.sink  req_if,
   lpcfsl_len_if.source rsp_if
);

   typedef struct packed {
      logic       stop;
      logic [2:0] kind;
      logic [4:0] rem;
      logic [5:0] acc;
      logic       rep;
   } walk_type;

   // Width of the field of a given kind
   function automatic logic [4:0] field_width(logic [2:0] kind);
      logic [4:0] w;
      case (kind)
         KIND_REPEAT: w = REPEAT_WIDTH;
         KIND_PITCH:  w = PITCH_WIDTH;
         KIND_KLOW:   w = KLOW_WIDTH;
         KIND_KHIGH:  w = KHIGH_WIDTH;
         default:     w = ENERGY_WIDTH;
      endcase
      return w;
   endfunction

   // Consume one bit of the stream
   function automatic walk_type step_bit(walk_type cur, logic b);
      walk_type   nxt;
      logic [2:0] kind;
      logic [4:0] width;
      logic [4:0] rem;
      logic [2:0] shift;
      nxt      = cur;
      nxt.stop = 1'b0;
      kind     = (cur.kind > KIND_KHIGH) ? KIND_ENERGY : cur.kind;
      width    = field_width(kind);
      rem      = (cur.rem == 5'd0 || cur.rem > width) ? width : cur.rem;
      if (kind == KIND_ENERGY || kind == KIND_REPEAT || kind == KIND_PITCH) begin
         shift   = 3'(width - rem);
         nxt.acc = cur.acc | (6'(b) << shift);
      end
      rem     = rem - 5'd1;
      nxt.rem = rem;
      if (rem == 5'd0) begin
         case (kind)
            KIND_ENERGY: begin
               if (nxt.acc == ENERGY_STOP) begin
                  nxt.stop = 1'b1;
                  nxt.kind = KIND_ENERGY;
                  nxt.rem  = ENERGY_WIDTH;
                  nxt.acc  = '0;
                  nxt.rep  = 1'b0;
               end else if (nxt.acc == ENERGY_SILENT) begin
                  nxt.kind = KIND_ENERGY;
                  nxt.rem  = ENERGY_WIDTH;
                  nxt.acc  = '0;
               end else begin
                  nxt.kind = KIND_REPEAT;
                  nxt.rem  = REPEAT_WIDTH;
                  nxt.acc  = '0;
               end
            end
            KIND_REPEAT: begin
               nxt.rep  = nxt.acc[0];
               nxt.kind = KIND_PITCH;
               nxt.rem  = PITCH_WIDTH;
               nxt.acc  = '0;
            end
            KIND_PITCH: begin
               if (cur.rep) begin
                  nxt.kind = KIND_ENERGY;
                  nxt.rem  = ENERGY_WIDTH;
                  nxt.acc  = '0;
               end else begin
                  // keep the pitch in the accumulator
                  nxt.kind = KIND_KLOW;
                  nxt.rem  = KLOW_WIDTH;
               end
            end
            KIND_KLOW: begin
               if (nxt.acc != 6'd0) begin
                  nxt.kind = KIND_KHIGH;
                  nxt.rem  = KHIGH_WIDTH;
               end else begin
                  nxt.kind = KIND_ENERGY;
                  nxt.rem  = ENERGY_WIDTH;
               end
               nxt.acc = '0;
            end
            default: begin
               nxt.kind = KIND_ENERGY;
               nxt.rem  = ENERGY_WIDTH;
               nxt.acc  = '0;
            end
         endcase
      end
      return nxt;
   endfunction

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   logic                   in_valid_ff;
   logic [BYTE_BITS-1:0]   byte_ff;
   logic                   out_valid_ff;
   logic [OUT_BITS-1:0]    length_ff;
   logic [2:0]             kind_ff;
   logic [4:0]             rem_ff;
   logic [5:0]             acc_ff;
   logic                   rep_ff;
   logic [LENGTH_BITS-1:0] seen_ff;

   logic                   advance;
   logic                   fire;
   walk_type               walk_in;
   logic [LENGTH_BITS-1:0] seen_inc;
   logic [LENGTH_BITS-1:0] seen_in;
   logic [31:0]            seen_wide;
   logic [OUT_BITS-1:0]    length_in;

   // Handshake: the input register moves on whenever the result slot is free or its result is taken
   assign advance       = !out_valid_ff || rsp_if.ready;
   assign fire          = in_valid_ff && advance;
   assign req_if.ready  = !in_valid_ff || advance;
   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.stream_length = length_ff;

   // Walk the eight bits of the held byte, most significant first; drop the rest
   // of the byte once the stop frame completes
   always_comb begin
      walk_in = '{stop: 1'b0, kind: kind_ff, rem: rem_ff, acc: acc_ff, rep: rep_ff};
      for (int i = BYTE_BITS - 1; i >= 0; i--) begin
         if (!walk_in.stop) begin
            walk_in = step_bit(walk_in, byte_ff[i]);
         end
      end
   end

   // Count bytes, saturating; cap the reported length
   always_comb begin
      seen_inc  = (seen_ff == COUNT_MAX) ? seen_ff : seen_ff + 1'b1;
      seen_in   = walk_in.stop ? '0 : seen_inc;
      seen_wide = 32'(seen_inc);
      length_in = (seen_wide > 32'(16'hFFFF)) ? 16'hFFFF : seen_wide[OUT_BITS-1:0];
   end

   // Control and walk state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         kind_ff      <= KIND_ENERGY;
         rem_ff       <= ENERGY_WIDTH;
         acc_ff       <= '0;
         rep_ff       <= 1'b0;
         seen_ff      <= '0;
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (advance) begin
            out_valid_ff <= fire && walk_in.stop;
         end
         if (fire) begin
            kind_ff <= walk_in.kind;
            rem_ff  <= walk_in.rem;
            acc_ff  <= walk_in.acc;
            rep_ff  <= walk_in.rep;
            seen_ff <= seen_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         byte_ff <= req_if.stream_byte;
      end
      if (fire && walk_in.stop) begin
         length_ff <= length_in;
      end
   end

endmodule
